// ===== hw/rtl/wdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// wdcd_pkg
// Shared types, widths and constants of the window deviation contact detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wdcd_pkg;

  // window length default
  localparam int unsigned WINDOW_DEF = 10;

  // field widths
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned THR_W     = 12;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned REF_W     = 16;
  localparam int unsigned DEV_OUT_W = 16;
  localparam int unsigned RES_W     = 30;

  // sample range
  localparam int unsigned FULL_SCALE = 4096;
  localparam int unsigned SAMPLE_MAX = 4095;

  // resistance arithmetic: ref * (4096 - s) is 16 x 13 bits, then times four
  localparam int unsigned SPAN_W     = 13;
  localparam int unsigned PROD_W     = REF_W + SPAN_W;
  localparam int unsigned DIVIDEND_W = PROD_W + 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  // configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register reset values
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 12'd150;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST   = 16'd1000;
  localparam logic [REF_W-1:0]  REFERENCE_RST = 16'd217;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_HOLDOFF   = 2'd1,
    REG_REFERENCE = 2'd2
  } reg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_UPDATE = 2'd1,
    ST_EVAL   = 2'd2,
    ST_DIVIDE = 2'd3
  } state_t;

  // input item
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample_echo;
    logic [DEV_OUT_W-1:0] deviation_scaled;
    logic                 window_full;
    logic                 contact;
    logic [RES_W-1:0]     resistance_quarter_ohms;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic update;
    logic eval;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wdcd_div.sv =====
// ----------------------------------------------------------------------------
// wdcd_div
// Restoring radix-2 divider, one quotient bit per cycle, for the resistance.
// ----------------------------------------------------------------------------
`default_nettype none

module wdcd_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [wdcd_pkg::DIVIDEND_W-1:0]      dividend,
  input  wire logic [wdcd_pkg::SAMPLE_W-1:0]        divisor,
  output logic                                      busy,
  output logic [wdcd_pkg::DIVIDEND_W-1:0]           quotient
);

  localparam int unsigned DW = wdcd_pkg::DIVIDEND_W;
  localparam int unsigned SW = wdcd_pkg::SAMPLE_W;
  localparam int unsigned CW = wdcd_pkg::DIV_CNT_W;

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] dsr_r, dsr_nxt;
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          qbit;

  // one shift-and-subtract step
  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, dsr_r};
    qbit     = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[SW-1:0] : trial[SW-1:0];
      quo_nxt = {quo_r[DW-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/wdcd_dp.sv =====
// ----------------------------------------------------------------------------
// wdcd_dp
// Datapath: sample window memory, running sum, deviation and contact test,
// resistance product and divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wdcd_dp #(
  parameter int unsigned WINDOW = wdcd_pkg::WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire wdcd_pkg::dp_cmd_t                 cmd,
  output wdcd_pkg::dp_status_t                   status,
  input  wire wdcd_pkg::in_item_t                in_item,
  input  wire logic [wdcd_pkg::THR_W-1:0]        threshold,
  input  wire logic [wdcd_pkg::HOLD_W-1:0]       holdoff_ms,
  input  wire logic [wdcd_pkg::REF_W-1:0]        reference_ohms,
  output wdcd_pkg::out_item_t                    out_item
);

  localparam int unsigned SW    = wdcd_pkg::SAMPLE_W;
  localparam int unsigned TW    = wdcd_pkg::TIME_W;
  localparam int unsigned OW    = wdcd_pkg::DEV_OUT_W;
  localparam int unsigned SUM_W = $clog2(WINDOW * wdcd_pkg::SAMPLE_MAX + 1);
  localparam int unsigned DEV_W = (SUM_W > OW) ? SUM_W : OW;
  localparam int unsigned PTR_W = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned PW    = wdcd_pkg::PROD_W;
  localparam int unsigned DW    = wdcd_pkg::DIVIDEND_W;
  localparam int unsigned SPW   = wdcd_pkg::SPAN_W;

  // window memory
  logic [SW-1:0] mem [WINDOW];
  logic [SW-1:0] rd_data_r;

  logic [SW-1:0]     samp_r;
  logic [TW-1:0]     now_r;
  logic [PW-1:0]     prod_r;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [TW-1:0]     last_alert_r, last_alert_nxt;
  logic [OW-1:0]     dev_r;
  logic              full_r;
  logic              contact_r;
  wdcd_pkg::out_item_t out_r;

  logic              was_full;
  logic              now_full;
  logic [SUM_W-1:0]  scaled;
  logic [SUM_W-1:0]  dev;
  logic [SUM_W-1:0]  limit;
  logic [DEV_W-1:0]  dev_ext;
  logic [OW-1:0]     dev_sat;
  logic [TW-1:0]     elapsed;
  logic              hit;
  logic [SPW-1:0]    span;
  logic [DW-1:0]     quotient;
  logic              div_busy;

  // capture the item, read the oldest entry, form ref * (4096 - s)
  assign span = SPW'(wdcd_pkg::FULL_SCALE) - SPW'(in_item.sample);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r    <= in_item.sample;
      now_r     <= in_item.now_ms;
      prod_r    <= PW'(reference_ohms) * PW'(span);
      rd_data_r <= mem[wp_r];
    end
    if (cmd.update) begin
      mem[wp_r] <= samp_r;
    end
  end

  // window bookkeeping
  assign was_full = (fill_r == FILL_W'(WINDOW));

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (cmd.update) begin
      sum_nxt = sum_r - (was_full ? SUM_W'(rd_data_r) : '0) + SUM_W'(samp_r);
      wp_nxt  = (wp_r == PTR_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
      if (!was_full) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  // deviation and contact decision on the updated window
  assign now_full = was_full;
  assign scaled   = SUM_W'(WINDOW) * SUM_W'(samp_r);
  assign dev      = now_full ? ((scaled >= sum_r) ? scaled - sum_r : sum_r - scaled) : '0;
  assign limit    = SUM_W'(WINDOW) * SUM_W'(threshold);
  assign elapsed  = now_r - last_alert_r;
  assign hit      = now_full && (dev > limit) && (elapsed > TW'(holdoff_ms));
  assign dev_ext  = DEV_W'(dev);
  assign dev_sat  = (dev_ext > DEV_W'({OW{1'b1}})) ? {OW{1'b1}} : dev_ext[OW-1:0];

  always_comb begin
    last_alert_nxt = last_alert_r;
    if (cmd.eval && hit) begin
      last_alert_nxt = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      last_alert_r <= '0;
    end else begin
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      sum_r        <= sum_nxt;
      last_alert_r <= last_alert_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dev_r     <= dev_sat;
      full_r    <= now_full;
      contact_r <= hit;
    end
  end

  // resistance divider, started with the window update
  wdcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.update),
    .dividend ({prod_r, 2'b00}),
    .divisor  (samp_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign status.div_busy = div_busy;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.sample_echo             <= samp_r;
      out_r.deviation_scaled        <= dev_r;
      out_r.window_full             <= full_r;
      out_r.contact                 <= contact_r;
      out_r.resistance_quarter_ohms <= (samp_r == '0) ? '0 :
                                       quotient[wdcd_pkg::RES_W-1:0];
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/wdcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wdcd_ctrl
// Sequencer: takes one item, steps the datapath and hands the result over.
// ----------------------------------------------------------------------------
`default_nettype none

module wdcd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output wdcd_pkg::dp_cmd_t          cmd,
  input  wire wdcd_pkg::dp_status_t  status
);

  wdcd_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      wdcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = wdcd_pkg::ST_UPDATE;
        end
      end
      wdcd_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = wdcd_pkg::ST_EVAL;
      end
      wdcd_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = wdcd_pkg::ST_DIVIDE;
      end
      wdcd_pkg::ST_DIVIDE: begin
        if (!status.div_busy && (!out_valid_r || !out_stall)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = wdcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wdcd_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wdcd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != wdcd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/window_deviation_contact_detector_top.sv =====
// ----------------------------------------------------------------------------
// window_deviation_contact_detector_top
// Moving-window deviation contact detector with alert holdoff and sensor
// resistance output.
// ----------------------------------------------------------------------------
// Usage
//   in_*   : one pressure sample with its millisecond timestamp per transfer;
//            a transfer happens at a clock edge with in_valid high and
//            in_stall low.
//   out_*  : one result per input transfer, in order, held while out_stall
//            is high.
//   cfg_*  : register port, threshold at 0x0, holdoff_ms at 0x4,
//            reference_ohms at 0x8; write only while the block is idle.
// Sequencing
//   out_valid rises after the sequencer has passed its update, evaluate and
//   divide states. The resistance division yields one quotient bit per
//   cycle, and no new item is taken until the last one's result is loaded
//   into the output register. The next input is taken while a finished
//   result still waits in the output register; a stalled output holds the
//   block only when the following result is ready.
// Reset
//   rst_n clears the window (fill count, sum, pointer), the last alert time
//   and both channels, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module window_deviation_contact_detector_top #(
  parameter int unsigned WINDOW = wdcd_pkg::WINDOW_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire wdcd_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output wdcd_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [wdcd_pkg::PADDR_W-1:0]       cfg_paddr,
  input  wire logic [wdcd_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic [wdcd_pkg::PDATA_W-1:0]            cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int unsigned PW = wdcd_pkg::PDATA_W;

  logic [wdcd_pkg::THR_W-1:0]  threshold_r, threshold_nxt;
  logic [wdcd_pkg::HOLD_W-1:0] holdoff_r, holdoff_nxt;
  logic [wdcd_pkg::REF_W-1:0]  reference_r, reference_nxt;
  logic                        wr_en;
  wdcd_pkg::reg_idx_t          reg_idx;
  wdcd_pkg::dp_cmd_t           cmd;
  wdcd_pkg::dp_status_t        status;

  // register write decode
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = wdcd_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    threshold_nxt = threshold_r;
    holdoff_nxt   = holdoff_r;
    reference_nxt = reference_r;
    if (wr_en) begin
      unique case (reg_idx)
        wdcd_pkg::REG_THRESHOLD: threshold_nxt = cfg_pwdata[wdcd_pkg::THR_W-1:0];
        wdcd_pkg::REG_HOLDOFF:   holdoff_nxt   = cfg_pwdata[wdcd_pkg::HOLD_W-1:0];
        wdcd_pkg::REG_REFERENCE: reference_nxt = cfg_pwdata[wdcd_pkg::REF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= wdcd_pkg::THRESHOLD_RST;
      holdoff_r   <= wdcd_pkg::HOLDOFF_RST;
      reference_r <= wdcd_pkg::REFERENCE_RST;
    end else begin
      threshold_r <= threshold_nxt;
      holdoff_r   <= holdoff_nxt;
      reference_r <= reference_nxt;
    end
  end

  // register read mux
  always_comb begin
    unique case (reg_idx)
      wdcd_pkg::REG_THRESHOLD: cfg_prdata = PW'(threshold_r);
      wdcd_pkg::REG_HOLDOFF:   cfg_prdata = PW'(holdoff_r);
      wdcd_pkg::REG_REFERENCE: cfg_prdata = PW'(reference_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // sequencer
  wdcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath
  wdcd_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_item        (in_data),
    .threshold      (threshold_r),
    .holdoff_ms     (holdoff_r),
    .reference_ohms (reference_r),
    .out_item       (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/wdcd_chk.sv =====
// ----------------------------------------------------------------------------
// wdcd_chk
// Port-level checks of the contact detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wdcd_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire wdcd_pkg::out_item_t  out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time: after a transfer in, the input is stalled
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // no deviation or contact before the window is full
  a_not_full_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.window_full |->
      out_data.deviation_scaled == '0 && !out_data.contact)
    else $error("deviation or contact with partial window");

  // zero sample gives zero resistance
  a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sample_echo == '0 |->
      out_data.resistance_quarter_ohms == '0)
    else $error("nonzero resistance for zero sample");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind window_deviation_contact_detector_top wdcd_chk u_wdcd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
